/* rtl/pds_pkg.sv */
// Package for the polygon signed distance block: widths, limits, codes and state types.
// No dependencies; imported by polygon_signed_distance_top.
package pds_pkg;

   localparam int MAX_VERTICES_DEF = 64;

   localparam int COORD_W  = 32;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int WIDE_W   = 128;
   localparam int QUO_W    = 61;
   localparam int DREM_W   = 67;
   localparam int ROOT_W   = 34;
   localparam int SRC_W    = 2 * ROOT_W;
   localparam int SREM_W   = ROOT_W + 2;
   localparam int LDIST_W  = 30;
   localparam int DIST_W   = 31;
   localparam int EDGE_W   = 6;

   localparam int MUL_CHUNK = 11;
   localparam int MUL_STEPS = DIFF_W / MUL_CHUNK;

   localparam logic [LDIST_W-1:0] DIST_CAP = 30'd655360000;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_FETCH = 11'b000_0000_0010,
      S_TAKE  = 11'b000_0000_0100,
      S_DIFF  = 11'b000_0000_1000,
      S_SETUP = 11'b000_0001_0000,
      S_MUL   = 11'b000_0010_0000,
      S_MACC  = 11'b000_0100_0000,
      S_DIV   = 11'b000_1000_0000,
      S_SQRT  = 11'b001_0000_0000,
      S_BEST  = 11'b010_0000_0000,
      S_NEXT  = 11'b100_0000_0000
   } state_type;

   typedef enum logic [3:0] {
      STEP_UXVX = 4'd0,
      STEP_UYVY = 4'd1,
      STEP_UXUX = 4'd2,
      STEP_UYUY = 4'd3,
      STEP_VXVX = 4'd4,
      STEP_VYVY = 4'd5,
      STEP_WXWX = 4'd6,
      STEP_WYWY = 4'd7,
      STEP_UXVY = 4'd8,
      STEP_UYVX = 4'd9,
      STEP_HH   = 4'd10,
      STEP_HL   = 4'd11,
      STEP_LL   = 4'd12,
      STEP_LHS  = 4'd13,
      STEP_RHS  = 4'd14
   } step_type;

endpackage

/* rtl/polygon_signed_distance_top.sv */
// Polygon signed distance block: vertex memory, shared multiplier, divider and root unit.
// Depends on pds_pkg.
//
//   channel   ports                                         direction
//   req       req_valid/req_ready, operation, point_x/y      in
//   rsp       rsp_valid/rsp_ready, status, distance, edges   out
//
// Clear and append are answered in the cycle after they are taken. A query runs each
// edge through 6 to 11 products on one 33x11 multiplier, then a two-bit-per-cycle square
// root; a one-bit-per-cycle divider runs first when the foot lies inside the edge.
// Reset is synchronous and clears the vertex count; the vertex memory is not cleared.
// A waiting result does not block a transfer on req when rsp_ready is high.
module polygon_signed_distance_top
   import pds_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_operation,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic signed [DIST_W-1:0]  rsp_signed_distance,
   output logic                      rsp_inside_res,
   output logic [EDGE_W-1:0]         rsp_edge_start,
   output logic [EDGE_W-1:0]         rsp_edge_end
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W = $clog2(MAX_VERTICES);

   logic [2*COORD_W-1:0] vtx_mem [MAX_VERTICES];
   logic [2*COORD_W-1:0] rd_ff;
   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
   logic [2*COORD_W-1:0] mem_wdata;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [DIST_W-1:0]        rsp_dist_ff, rsp_dist_in;
   logic                     rsp_inside_ff, rsp_inside_in;
   logic [EDGE_W-1:0]        rsp_es_ff, rsp_es_in, rsp_ee_ff, rsp_ee_in;

   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic                      first_ff, first_in;
   logic [CNT_W-1:0]          j_ff, j_in;
   logic [ADDR_W-1:0]         i_ff, i_in;

   logic signed [DIFF_W-1:0] vx_ff, vx_in, vy_ff, vy_in, ux_ff, ux_in, uy_ff, uy_in;
   logic signed [DIFF_W-1:0] wx_ff, wx_in, wy_ff, wy_in, dy_ff, dy_in;
   logic signed [DIFF_W-1:0] qx_ff, qx_in, qy_ff, qy_in;

   step_type step_ff, step_in;
   logic [DIFF_W-1:0] mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic              neg_ff, neg_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]        mcnt_ff, mcnt_in;

   logic signed [ACC_W-1:0] acc_ff, acc_in, dot_ff, dot_in, len2_ff, len2_in;
   logic [COORD_W-1:0]      crh_ff, crh_in, crl_ff, crl_in;
   logic [WIDE_W-1:0]       wide_ff, wide_in;
   logic [DREM_W-1:0]       drem_ff, drem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [6:0]              cnt_ff, cnt_in;
   logic [SRC_W-1:0]        src_ff, src_in;
   logic [SREM_W-1:0]       srem_ff, srem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;

   logic [LDIST_W-1:0] ldist_ff, ldist_in, best_ff, best_in;
   logic [ADDR_W-1:0]  bs_ff, bs_in, be_ff, be_in;
   logic               inside_ff, inside_in;

   logic signed [DIFF_W-1:0] opa, opb;
   logic [DIFF_W-1:0]        opa_mag, opb_mag;
   logic signed [ACC_W-1:0]  psig, sum, diff;
   logic [ACC_W-1:0]         cr_abs;
   logic [DREM_W-1:0]        r2;
   logic [SREM_W+1:0]        rem_t, trial;
   logic [CNT_W-1:0]         cm1, jn;
   logic [DIST_W-1:0]        best_ext;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_signed_distance = rsp_dist_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_edge_start = rsp_es_ff;
   assign rsp_edge_end = rsp_ee_ff;

   assign cm1 = count_ff - 1'b1;
   assign jn = j_ff + 1'b1;
   assign best_ext = {1'b0, best_ff};

   always_comb begin
      case (step_ff)
         STEP_UXVX: begin opa = ux_ff; opb = vx_ff; end
         STEP_UYVY: begin opa = uy_ff; opb = vy_ff; end
         STEP_UXUX: begin opa = ux_ff; opb = ux_ff; end
         STEP_UYUY: begin opa = uy_ff; opb = uy_ff; end
         STEP_VXVX: begin opa = vx_ff; opb = vx_ff; end
         STEP_VYVY: begin opa = vy_ff; opb = vy_ff; end
         STEP_WXWX: begin opa = wx_ff; opb = wx_ff; end
         STEP_WYWY: begin opa = wy_ff; opb = wy_ff; end
         STEP_UXVY: begin opa = ux_ff; opb = vy_ff; end
         STEP_UYVX: begin opa = uy_ff; opb = vx_ff; end
         STEP_HH:   begin opa = {1'b0, crh_ff}; opb = {1'b0, crh_ff}; end
         STEP_HL:   begin opa = {1'b0, crh_ff}; opb = {1'b0, crl_ff}; end
         STEP_LL:   begin opa = {1'b0, crl_ff}; opb = {1'b0, crl_ff}; end
         STEP_LHS:  begin opa = wx_ff; opb = dy_ff; end
         STEP_RHS:  begin opa = qx_ff; opb = qy_ff; end
         default:   begin opa = '0; opb = '0; end
      endcase
   end

   assign opa_mag = opa[DIFF_W-1] ? DIFF_W'(-opa) : DIFF_W'(opa);
   assign opb_mag = opb[DIFF_W-1] ? DIFF_W'(-opb) : DIFF_W'(opb);
   assign psig = neg_ff ? -$signed({2'b00, prod_ff}) : $signed({2'b00, prod_ff});
   assign sum = acc_ff + psig;
   assign diff = acc_ff - psig;
   assign cr_abs = diff[ACC_W-1] ? ACC_W'(-diff) : ACC_W'(diff);
   assign r2 = {drem_ff[DREM_W-2:0], wide_ff[QUO_W-1]};
   assign rem_t = {srem_ff, src_ff[SRC_W-1:SRC_W-2]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_es_in = rsp_es_ff;
      rsp_ee_in = rsp_ee_ff;
      px_in = px_ff; py_in = py_ff;
      sx_in = sx_ff; sy_in = sy_ff; ex_in = ex_ff; ey_in = ey_ff;
      first_in = first_ff; j_in = j_ff; i_in = i_ff;
      vx_in = vx_ff; vy_in = vy_ff; ux_in = ux_ff; uy_in = uy_ff;
      wx_in = wx_ff; wy_in = wy_ff; dy_in = dy_ff; qx_in = qx_ff; qy_in = qy_ff;
      step_in = step_ff;
      mag_a_in = mag_a_ff; mag_b_in = mag_b_ff; neg_in = neg_ff;
      prod_in = prod_ff; mcnt_in = mcnt_ff;
      acc_in = acc_ff; dot_in = dot_ff; len2_in = len2_ff;
      crh_in = crh_ff; crl_in = crl_ff; wide_in = wide_ff;
      drem_in = drem_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      src_in = src_ff; srem_in = srem_ff; root_in = root_ff;
      ldist_in = ldist_ff; best_in = best_ff; bs_in = bs_ff; be_in = be_ff;
      inside_in = inside_ff;
      mem_we = 1'b0; mem_re = 1'b0;
      mem_waddr = count_ff[ADDR_W-1:0];
      mem_wdata = {req_point_x, req_point_y};
      mem_raddr = first_ff ? cm1[ADDR_W-1:0] : j_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STS_OK;
               rsp_dist_in = '0;
               rsp_inside_in = 1'b0;
               rsp_es_in = '0;
               rsp_ee_in = '0;
               case (req_operation)
                  OP_CLEAR: count_in = '0;
                  OP_APPEND: begin
                     if (count_ff >= CNT_W'(MAX_VERTICES)) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        mem_we = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STS_EMPTY;
                        rsp_dist_in = {1'b0, DIST_CAP};
                     end else begin
                        rsp_valid_in = 1'b0;
                        px_in = req_point_x;
                        py_in = req_point_y;
                        first_in = 1'b1;
                        j_in = '0;
                        best_in = DIST_CAP;
                        bs_in = '0;
                        be_in = cm1[ADDR_W-1:0];
                        inside_in = 1'b0;
                        state_in = S_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            mem_re = 1'b1;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            if (first_ff) begin
               sx_in = rd_ff[2*COORD_W-1:COORD_W];
               sy_in = rd_ff[COORD_W-1:0];
               i_in = cm1[ADDR_W-1:0];
               first_in = 1'b0;
               state_in = S_FETCH;
            end else begin
               ex_in = rd_ff[2*COORD_W-1:COORD_W];
               ey_in = rd_ff[COORD_W-1:0];
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            vx_in = DIFF_W'(px_ff) - DIFF_W'(sx_ff);
            vy_in = DIFF_W'(py_ff) - DIFF_W'(sy_ff);
            ux_in = DIFF_W'(ex_ff) - DIFF_W'(sx_ff);
            uy_in = DIFF_W'(ey_ff) - DIFF_W'(sy_ff);
            wx_in = DIFF_W'(px_ff) - DIFF_W'(ex_ff);
            wy_in = DIFF_W'(py_ff) - DIFF_W'(ey_ff);
            dy_in = DIFF_W'(sy_ff) - DIFF_W'(ey_ff);
            qx_in = DIFF_W'(sx_ff) - DIFF_W'(ex_ff);
            qy_in = DIFF_W'(py_ff) - DIFF_W'(ey_ff);
            step_in = STEP_UXVX;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            mag_a_in = opa_mag;
            mag_b_in = opb_mag;
            neg_in = opa[DIFF_W-1] ^ opb[DIFF_W-1];
            prod_in = '0;
            mcnt_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = (prod_ff << MUL_CHUNK)
                    + PROD_W'(mag_a_ff * mag_b_ff[DIFF_W-1 -: MUL_CHUNK]);
            mag_b_in = mag_b_ff << MUL_CHUNK;
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 2'(MUL_STEPS - 1)) begin
               state_in = S_MACC;
            end
         end
         S_MACC: begin
            state_in = S_SETUP;
            case (step_ff)
               STEP_UXVX: begin acc_in = psig; step_in = STEP_UYVY; end
               STEP_UYVY: begin dot_in = sum; step_in = STEP_UXUX; end
               STEP_UXUX: begin acc_in = psig; step_in = STEP_UYUY; end
               STEP_UYUY: begin
                  len2_in = sum;
                  if (dot_ff[ACC_W-1] || dot_ff == '0) begin
                     step_in = STEP_VXVX;
                  end else if (dot_ff >= sum) begin
                     step_in = STEP_WXWX;
                  end else begin
                     step_in = STEP_UXVY;
                  end
               end
               STEP_VXVX: begin acc_in = psig; step_in = STEP_VYVY; end
               STEP_WXWX: begin acc_in = psig; step_in = STEP_WYWY; end
               STEP_VYVY, STEP_WYWY: begin
                  src_in = SRC_W'(sum);
                  srem_in = '0;
                  root_in = '0;
                  cnt_in = '0;
                  state_in = S_SQRT;
               end
               STEP_UXVY: begin acc_in = psig; step_in = STEP_UYVX; end
               STEP_UYVX: begin
                  if (cr_abs[ACC_W-1:2*COORD_W] != '0) begin
                     ldist_in = DIST_CAP;
                     state_in = S_BEST;
                  end else begin
                     crh_in = cr_abs[2*COORD_W-1:COORD_W];
                     crl_in = cr_abs[COORD_W-1:0];
                     step_in = STEP_HH;
                  end
               end
               STEP_HH: begin
                  wide_in = {prod_ff[2*COORD_W-1:0], (2*COORD_W)'(0)};
                  step_in = STEP_HL;
               end
               STEP_HL: begin
                  wide_in = wide_ff + (WIDE_W'(prod_ff) << (COORD_W + 1));
                  step_in = STEP_LL;
               end
               STEP_LL: begin
                  wide_in = wide_ff + WIDE_W'(prod_ff);
                  cnt_in = '0;
                  state_in = S_DIV;
               end
               STEP_LHS: begin acc_in = psig; step_in = STEP_RHS; end
               STEP_RHS: begin
                  if ((!dy_ff[DIFF_W-1] && dy_ff != '0 && acc_ff < psig) ||
                      (dy_ff[DIFF_W-1] && acc_ff > psig)) begin
                     inside_in = !inside_ff;
                  end
                  state_in = S_NEXT;
               end
               default: state_in = S_NEXT;
            endcase
         end
         S_DIV: begin
            if (cnt_ff == '0) begin
               if (wide_ff[WIDE_W-1:QUO_W] >= DREM_W'(len2_ff)) begin
                  ldist_in = DIST_CAP;
                  state_in = S_BEST;
               end else begin
                  drem_in = wide_ff[WIDE_W-1:QUO_W];
                  cnt_in = 7'd1;
               end
            end else begin
               if (r2 >= DREM_W'(len2_ff)) begin
                  drem_in = r2 - DREM_W'(len2_ff);
                  quo_in = {quo_ff[QUO_W-2:0], 1'b1};
               end else begin
                  drem_in = r2;
                  quo_in = {quo_ff[QUO_W-2:0], 1'b0};
               end
               wide_in = wide_ff << 1;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == 7'(QUO_W)) begin
                  cnt_in = '0;
                  if (quo_in[QUO_W-1]) begin
                     ldist_in = DIST_CAP;
                     state_in = S_BEST;
                  end else begin
                     src_in = SRC_W'(quo_in[QUO_W-2:0]);
                     srem_in = '0;
                     root_in = '0;
                     state_in = S_SQRT;
                  end
               end
            end
         end
         S_SQRT: begin
            if (rem_t >= trial) begin
               srem_in = SREM_W'(rem_t - trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = SREM_W'(rem_t);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            src_in = src_ff << 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 7'(ROOT_W - 1)) begin
               ldist_in = (root_in > ROOT_W'(DIST_CAP)) ? DIST_CAP : root_in[LDIST_W-1:0];
               state_in = S_BEST;
            end
         end
         S_BEST: begin
            if (best_ff > ldist_ff) begin
               best_in = ldist_ff;
               bs_in = i_ff;
               be_in = j_ff[ADDR_W-1:0];
            end
            if ((ey_ff > py_ff) != (sy_ff > py_ff)) begin
               step_in = STEP_LHS;
               state_in = S_SETUP;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            sx_in = ex_ff;
            sy_in = ey_ff;
            i_in = j_ff[ADDR_W-1:0];
            j_in = jn;
            if (jn == count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STS_OK;
               rsp_dist_in = inside_ff ? DIST_W'(-best_ext) : best_ext;
               rsp_inside_in = inside_ff;
               rsp_es_in = EDGE_W'(bs_ff);
               rsp_ee_in = EDGE_W'(be_ff);
               state_in = S_IDLE;
            end else begin
               state_in = S_FETCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vtx_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= vtx_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_es_ff <= rsp_es_in;
      rsp_ee_ff <= rsp_ee_in;
      px_ff <= px_in; py_ff <= py_in;
      sx_ff <= sx_in; sy_ff <= sy_in; ex_ff <= ex_in; ey_ff <= ey_in;
      first_ff <= first_in; j_ff <= j_in; i_ff <= i_in;
      vx_ff <= vx_in; vy_ff <= vy_in; ux_ff <= ux_in; uy_ff <= uy_in;
      wx_ff <= wx_in; wy_ff <= wy_in; dy_ff <= dy_in; qx_ff <= qx_in; qy_ff <= qy_in;
      step_ff <= step_in;
      mag_a_ff <= mag_a_in; mag_b_ff <= mag_b_in; neg_ff <= neg_in;
      prod_ff <= prod_in; mcnt_ff <= mcnt_in;
      acc_ff <= acc_in; dot_ff <= dot_in; len2_ff <= len2_in;
      crh_ff <= crh_in; crl_ff <= crl_in; wide_ff <= wide_in;
      drem_ff <= drem_in; quo_ff <= quo_in; cnt_ff <= cnt_in;
      src_ff <= src_in; srem_ff <= srem_in; root_ff <= root_in;
      ldist_ff <= ldist_in; best_ff <= best_in; bs_ff <= bs_in; be_ff <= be_in;
      inside_ff <= inside_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count above capacity");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("result pending during a query");

   a_ldist_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BEST) |-> (ldist_ff <= DIST_CAP))
      else $error("edge distance above cap");

endmodule

/* tb/tb.sv */
// Self-checking testbench for polygon_signed_distance_top: clear, append and query traffic
// with an in-bench polygon distance predictor. Depends on pds_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb;
   import pds_pkg::*;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam int         ONE        = 65536;
   localparam int         CYCLE_LIMIT = 3_000_000;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [1:0]        status;
      logic [DIST_W-1:0] distance;
      logic              in_flag;
      logic [EDGE_W-1:0] edge_start;
      logic [EDGE_W-1:0] edge_end;
   } answer_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_operation;
   logic signed [COORD_W-1:0] req_point_x;
   logic signed [COORD_W-1:0] req_point_y;
   logic rsp_valid;
   logic rsp_ready;
   logic [1:0] rsp_status;
   logic signed [DIST_W-1:0] rsp_signed_distance;
   logic rsp_inside_res;
   logic [EDGE_W-1:0] rsp_edge_start;
   logic [EDGE_W-1:0] rsp_edge_end;

   polygon_signed_distance_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_operation(req_operation),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_signed_distance(rsp_signed_distance), .rsp_inside_res(rsp_inside_res),
      .rsp_edge_start(rsp_edge_start), .rsp_edge_end(rsp_edge_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [31:0] poly_x [MAX_VERTICES_DEF];
   logic signed [31:0] poly_y [MAX_VERTICES_DEF];
   int unsigned poly_count;
   answer_type expected_answers[$];
   int error_count;
   int items_sent;
   int send_idle_pct;
   int recv_stall_pct;
   longint cycle_count;

   function automatic wide_type mul_wide(longint a, longint b);
      wide_type wa, wb;
      wa = a;
      wb = b;
      return wa * wb;
   endfunction

   function automatic logic [63:0] root_floor(logic [127:0] n);
      logic [63:0]  r, c;
      logic [127:0] sq;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (64'd1 << b);
         sq = {64'd0, c} * {64'd0, c};
         if (sq <= n) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] edge_distance(longint px, longint py, longint sx,
                                                 longint sy, longint ex, longint ey);
      longint vx, vy, ux, uy, wx, wy;
      wide_type dot, len2, cr;
      logic [127:0] c2, t, q2;
      logic [63:0] l, q, cand;
      vx = px - sx; vy = py - sy; ux = ex - sx; uy = ey - sy;
      wx = px - ex; wy = py - ey;
      dot  = mul_wide(ux, vx) + mul_wide(uy, vy);
      len2 = mul_wide(ux, ux) + mul_wide(uy, uy);
      if (dot <= 0) begin
         l = root_floor(mul_wide(vx, vx) + mul_wide(vy, vy));
      end else if (dot >= len2) begin
         l = root_floor(mul_wide(wx, wx) + mul_wide(wy, wy));
      end else begin
         cr = mul_wide(ux, vy) - mul_wide(uy, vx);
         if (cr < 0) cr = -cr;
         if (cr[127:64] != 0) begin
            l = DIST_CAP;
         end else begin
            c2 = cr * cr;
            q = '0;
            for (int b = 29; b >= 0; b--) begin
               cand = q | (64'd1 << b);
               q2 = {64'd0, cand} * {64'd0, cand};
               t = len2 * q2;
               if (t <= c2) q = cand;
            end
            l = q;
         end
      end
      return (l > DIST_CAP) ? 64'(DIST_CAP) : l;
   endfunction

   function automatic logic point_is_inside(longint px, longint py);
      logic in_poly;
      longint xi, yi, xj, yj, dy;
      wide_type lhs, rhs;
      int unsigned j;
      in_poly = 1'b0;
      j = poly_count - 1;
      for (int unsigned i = 0; i < poly_count; i++) begin
         xi = poly_x[i]; yi = poly_y[i]; xj = poly_x[j]; yj = poly_y[j];
         if ((yi > py) != (yj > py)) begin
            dy = yj - yi;
            lhs = mul_wide(px - xi, dy);
            rhs = mul_wide(xj - xi, py - yi);
            if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs)) in_poly = !in_poly;
         end
         j = i;
      end
      return in_poly;
   endfunction

   function automatic answer_type predict_response(logic [1:0] op, logic signed [31:0] x,
                                                   logic signed [31:0] y);
      answer_type a;
      logic [63:0] best, l;
      int unsigned bs, be, i;
      a = '{default: '0};
      case (op)
         OP_CLEAR: poly_count = 0;
         OP_APPEND: begin
            if (poly_count >= MAX_VERTICES_DEF) begin
               a.status = STS_FULL;
            end else begin
               poly_x[poly_count] = x;
               poly_y[poly_count] = y;
               poly_count++;
            end
         end
         OP_QUERY: begin
            if (poly_count == 0) begin
               a.status = STS_EMPTY;
               a.distance = DIST_CAP;
            end else begin
               best = DIST_CAP;
               bs = 0;
               be = poly_count - 1;
               i = poly_count - 1;
               for (int unsigned j = 0; j < poly_count; j++) begin
                  l = edge_distance(x, y, poly_x[i], poly_y[i], poly_x[j], poly_y[j]);
                  if (best > l) begin
                     best = l; bs = i; be = j;
                  end
                  i = j;
               end
               a.in_flag = point_is_inside(x, y);
               a.distance = a.in_flag ? DIST_W'(64'd0 - best) : DIST_W'(best);
               a.edge_start = EDGE_W'(bs);
               a.edge_end = EDGE_W'(be);
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic send_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_point_x <= x;
      req_point_y <= y;
      do @(posedge clock); while (!req_ready);
      expected_answers.insert(expected_answers.size(), predict_response(op, x, y));
      items_sent++;
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      answer_type e;
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            $display("%0t unexpected transfer: expected none, actual status %h", $time,
                     rsp_status);
            error_count++;
         end else begin
            e = expected_answers.pop_front();
            check_field("status", 32'(e.status), 32'(rsp_status));
            check_field("signed_distance", 32'(e.distance),
                        32'($unsigned(rsp_signed_distance)));
            check_field("inside_res", 32'(e.in_flag), 32'(rsp_inside_res));
            check_field("edge_start", 32'(e.edge_start), 32'(rsp_edge_start));
            check_field("edge_end", 32'(e.edge_end), 32'(rsp_edge_end));
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_coord();
      if ($urandom_range(7) == 0) return $urandom;
      return int'($urandom_range(13107200)) - 6553600;
   endfunction

   task automatic test_directed();
      send_item(OP_QUERY, 0, 0);
      send_item(OP_IGNORED, 32'sh7fffffff, 32'sh80000000);
      send_item(OP_CLEAR, 0, 0);
      send_item(OP_APPEND, 0, 0);
      send_item(OP_APPEND, 10 * ONE, 0);
      send_item(OP_APPEND, 10 * ONE, 10 * ONE);
      send_item(OP_APPEND, 0, 10 * ONE);
      send_item(OP_QUERY, 5 * ONE, 5 * ONE);
      send_item(OP_QUERY, 15 * ONE, 5 * ONE);
      send_item(OP_QUERY, 12 * ONE, 12 * ONE);
      send_item(OP_QUERY, -3 * ONE, 4 * ONE);
      send_item(OP_APPEND, 0, 10 * ONE);
      send_item(OP_QUERY, 1 * ONE, 9 * ONE);
      send_item(OP_QUERY, 32'sh7fffffff, 32'sh7fffffff);
      send_item(OP_QUERY, 32'sh80000000, 32'sh80000000);
      send_item(OP_CLEAR, -1, -1);
      send_item(OP_APPEND, 32'sh80000000, 32'sh80000000);
      send_item(OP_APPEND, 32'sh7fffffff, 32'sh80000000);
      send_item(OP_APPEND, 32'sh7fffffff, 32'sh7fffffff);
      send_item(OP_QUERY, 0, 0);
      send_item(OP_QUERY, 32'sh7fffffff, 32'sh80000000);
      send_item(OP_IGNORED, 0, 0);
      send_item(OP_CLEAR, 0, 0);
   endtask

   task automatic test_full_list();
      send_item(OP_CLEAR, 0, 0);
      for (int k = 0; k < MAX_VERTICES_DEF; k++)
         send_item(OP_APPEND, int'($urandom_range(13107200)) - 6553600,
                   int'($urandom_range(13107200)) - 6553600);
      send_item(OP_APPEND, $urandom, $urandom);
      send_item(OP_APPEND, $urandom, $urandom);
      send_item(OP_QUERY, rand_coord(), rand_coord());
   endtask

   task automatic test_random_polygons(int budget);
      int stop_at, n;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(9) == 0) begin
            send_item(2'($urandom), $urandom, $urandom);
         end else begin
            send_item(OP_CLEAR, $urandom, $urandom);
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            for (int k = 0; k < n; k++) send_item(OP_APPEND, rand_coord(), rand_coord());
            n = $urandom_range(2, 5);
            for (int k = 0; k < n; k++) send_item(OP_QUERY, rand_coord(), rand_coord());
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_CLEAR;
      req_point_x <= '0;
      req_point_y <= '0;
      rsp_ready <= 1'b0;
      cycle_count = 0;
      error_count = 0;
      items_sent = 0;
      poly_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      send_idle_pct = 21; recv_stall_pct = 21;
      test_full_list();
      send_idle_pct = 0; recv_stall_pct = 0;
      test_random_polygons(30);
      send_idle_pct = 45; recv_stall_pct = 0;
      test_random_polygons(30);
      send_idle_pct = 0; recv_stall_pct = 45;
      test_random_polygons(30);
      send_idle_pct = 21; recv_stall_pct = 21;
      test_random_polygons(30);

      req_valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

/* polygon_signed_distance_top.f */
rtl/pds_pkg.sv
rtl/polygon_signed_distance_top.sv
tb/tb.sv
